[sv/bwca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_pkg
// Shared types and constants for the binary-weight convolution accumulator.
// ----------------------------------------------------------------------------
package bwca_pkg;

  localparam int LANES         = 8;
  localparam int ACT_W         = 16;
  localparam int ACC_W         = 32;
  localparam int TOT_W         = 20;   // 8 x 16-bit signed terms, worst case 2^18
  localparam int ROW_W         = LANES * ACC_W;
  localparam int IN_IDX_W      = 12;
  localparam int VCH_W         = 13;
  localparam int CACHE_ENTRIES = 4096;
  localparam int QUEUE_DEPTH   = 4;

  localparam int          CFG_DATA_W = 32;
  localparam int          CFG_ADDR_W = 3;
  localparam logic        CFG_IDX_VALID_CHANNELS = 1'b0;
  localparam logic [VCH_W-1:0] VALID_CHANNELS_RST = 13'd4096;

  localparam logic KIND_ACCUM = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic                             rd;
    logic [IN_IDX_W-1:0]              index;
    logic                             fresh;
    logic [LANES-1:0][TOT_W-1:0]      totals;
  } bwca_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bwca_q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bwca_bk_state_t;

endpackage

[sv/bwca_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_in_if
// Input channel: accumulate or read-out item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bwca_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] cache_index;
  logic        start_fresh;
  logic [11:0] channel_base;
  logic [63:0] activations_low;
  logic [63:0] activations_high;
  logic [63:0] weight_signs;

  modport source (
    output valid, kind, cache_index, start_fresh, channel_base,
           activations_low, activations_high, weight_signs,
    input  ready
  );

  modport sink (
    input  valid, kind, cache_index, start_fresh, channel_base,
           activations_low, activations_high, weight_signs,
    output ready
  );
endinterface

[sv/bwca_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_out_if
// Result channel: eight 32-bit lane sums of one store entry.
// ----------------------------------------------------------------------------
interface bwca_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sums_lanes_0_1;
  logic [63:0] sums_lanes_2_3;
  logic [63:0] sums_lanes_4_5;
  logic [63:0] sums_lanes_6_7;

  modport source (
    output valid, sums_lanes_0_1, sums_lanes_2_3, sums_lanes_4_5, sums_lanes_6_7,
    input  ready
  );

  modport sink (
    input  valid, sums_lanes_0_1, sums_lanes_2_3, sums_lanes_4_5, sums_lanes_6_7,
    output ready
  );
endinterface

[sv/bwca_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_front
// Accepts input beats, masks lanes by channel count and reduces each output
// lane's signed activation terms to one lane total for the queue.
// ----------------------------------------------------------------------------
module bwca_front (
  bwca_in_if.sink                              in_ch,
  input  logic [bwca_pkg::VCH_W-1:0]           valid_channels,
  input  bwca_pkg::bwca_q_stat_t               q_stat,
  output logic                                 push,
  output bwca_pkg::bwca_op_t                   op
);

  logic [2*bwca_pkg::LANES*bwca_pkg::ACT_W/2-1:0] acts_all;
  logic [bwca_pkg::LANES-1:0]                     live;
  logic [bwca_pkg::LANES-1:0][bwca_pkg::TOT_W-1:0] terms;
  logic [bwca_pkg::LANES-1:0][bwca_pkg::TOT_W-1:0] totals;

  assign acts_all    = {in_ch.activations_high, in_ch.activations_low};
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    logic [bwca_pkg::VCH_W-1:0] ch;
    logic [bwca_pkg::ACT_W-1:0] a;
    for (int p = 0; p < bwca_pkg::LANES; p++) begin
      ch       = bwca_pkg::VCH_W'(in_ch.channel_base) + bwca_pkg::VCH_W'(p);
      live[p]  = ch < valid_channels;
      a        = acts_all[p*bwca_pkg::ACT_W +: bwca_pkg::ACT_W];
      terms[p] = {{(bwca_pkg::TOT_W-bwca_pkg::ACT_W){a[bwca_pkg::ACT_W-1]}}, a};
    end
  end

  always_comb begin
    logic [bwca_pkg::LANES-1:0] bits;
    logic [bwca_pkg::TOT_W-1:0] acc;
    for (int q = 0; q < bwca_pkg::LANES; q++) begin
      bits = in_ch.weight_signs[q*bwca_pkg::LANES +: bwca_pkg::LANES];
      acc  = '0;
      for (int p = 0; p < bwca_pkg::LANES; p++) begin
        if (live[p]) begin
          acc = bits[p] ? (acc + terms[p]) : (acc - terms[p]);
        end
      end
      totals[q] = acc;
    end
  end

  always_comb begin
    op.rd     = (in_ch.kind == bwca_pkg::KIND_READ);
    op.index  = in_ch.cache_index;
    op.fresh  = in_ch.start_fresh;
    op.totals = totals;
  end

endmodule

[sv/bwca_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_fifo
// Short queue of classified operations between front and back ends.
// ----------------------------------------------------------------------------
module bwca_fifo #(
  parameter int DEPTH = bwca_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bwca_pkg::bwca_op_t     wr_op,
  input  logic                   pop,
  output bwca_pkg::bwca_op_t     rd_op,
  output bwca_pkg::bwca_q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bwca_pkg::bwca_op_t slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_op      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

[sv/bwca_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwca_back
// Partial-sum store with read-modify-write sequencer and result register.
// ----------------------------------------------------------------------------
module bwca_back #(
  parameter int CACHE_ENTRIES = bwca_pkg::CACHE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  bwca_pkg::bwca_op_t     q_op,
  output logic                   q_pop,
  bwca_out_if.source             out_ch
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int ROW_W = bwca_pkg::ROW_W;
  localparam int ACC_W = bwca_pkg::ACC_W;
  localparam int TOT_W = bwca_pkg::TOT_W;

  logic [ROW_W-1:0]          mem [CACHE_ENTRIES];
  bwca_pkg::bwca_bk_state_t  state_r, state_nxt;
  bwca_pkg::bwca_op_t        op_r;
  logic [ROW_W-1:0]          rd_row_r;
  logic [ROW_W-1:0]          new_row;
  logic [ROW_W-1:0]          sums_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      mem_we;
  logic                      load_out;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;

  assign rd_addr = IDX_W'(q_op.index);
  assign wr_addr = IDX_W'(op_r.index);

  always_comb begin
    logic [ACC_W-1:0] base;
    logic [TOT_W-1:0] t;
    for (int q = 0; q < bwca_pkg::LANES; q++) begin
      base = op_r.fresh ? '0 : rd_row_r[q*ACC_W +: ACC_W];
      t    = op_r.totals[q];
      new_row[q*ACC_W +: ACC_W] = base + {{(ACC_W-TOT_W){t[TOT_W-1]}}, t};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      bwca_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = bwca_pkg::BK_EXEC;
        end
      end
      bwca_pkg::BK_EXEC: begin
        if (!op_r.rd) begin
          mem_we    = 1'b1;
          state_nxt = bwca_pkg::BK_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bwca_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bwca_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bwca_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r     <= q_op;
      rd_row_r <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= new_row;
    end
    if (load_out) begin
      sums_r <= rd_row_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sums_lanes_0_1 = sums_r[63:0];
  assign out_ch.sums_lanes_2_3 = sums_r[127:64];
  assign out_ch.sums_lanes_4_5 = sums_r[191:128];
  assign out_ch.sums_lanes_6_7 = sums_r[255:192];

endmodule

[sv/binary_weight_conv_accumulate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_weight_conv_accumulate_unit
// Binary-weight convolution accumulator over a store of eight-lane partial sums.
// ----------------------------------------------------------------------------
// The front end takes one input beat per cycle while the queue (four deep) has
// room, masks lanes at or beyond valid_channels and reduces each output lane to
// one signed total. The back end pops each item and reads the store row in BK_IDLE,
// then writes the updated row (accumulate) or loads the result register (read)
// in BK_EXEC, and it takes no new item before it is through with the last one, as
// the single-port read-modify-write of the store demands. A read result waits in the
// output register without blocking later accumulates already queued behind it
// only until the next read reaches the back end. CACHE_ENTRIES must be a power
// of two; the index keeps its low bits. The store is not cleared after reset,
// so an entry must be written with start_fresh set before it is read or
// accumulated without start_fresh.
// ----------------------------------------------------------------------------
module binary_weight_conv_accumulate_unit #(
  parameter int CACHE_ENTRIES = bwca_pkg::CACHE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bwca_in_if.sink                           in_ch,
  bwca_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bwca_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bwca_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bwca_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [bwca_pkg::VCH_W-1:0] valid_channels_r, valid_channels_nxt;
  logic                       cfg_wr;
  logic                       cfg_hit;
  logic                       push;
  logic                       pop;
  bwca_pkg::bwca_op_t         push_op;
  bwca_pkg::bwca_op_t         head_op;
  bwca_pkg::bwca_q_stat_t     q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == bwca_pkg::CFG_IDX_VALID_CHANNELS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ?
                      bwca_pkg::CFG_DATA_W'(valid_channels_r) : '0;

  always_comb begin
    valid_channels_nxt = valid_channels_r;
    if (cfg_wr && cfg_hit) begin
      valid_channels_nxt = cfg_pwdata[bwca_pkg::VCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_channels_r <= bwca_pkg::VALID_CHANNELS_RST;
    end else begin
      valid_channels_r <= valid_channels_nxt;
    end
  end

  bwca_front u_front (
    .in_ch          (in_ch),
    .valid_channels (valid_channels_r),
    .q_stat         (q_stat),
    .push           (push),
    .op             (push_op)
  );

  bwca_fifo #(
    .DEPTH (bwca_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_op (push_op),
    .pop   (pop),
    .rd_op (head_op),
    .stat  (q_stat)
  );

  bwca_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_stat.empty),
    .q_op    (head_op),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_hit) |=> (valid_channels_r == $past(cfg_pwdata[12:0])))
    else $error("valid_channels not updated by write");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_stat.empty)
    else $error("queue empty after push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary-weight convolution accumulator.
// A table of directed beats runs first: extreme activations, full add and
// full subtract signs, lane masking at the channel limit, fresh restarts and
// reads whose unused fields carry junk. Phases of random convolution runs
// follow, each under its own channel count, followed by a run of
// accumulations at the activation extremes on two entries. Every read beat is checked
// against the typed sums of its table row or else a shadow of the partial-sum store.
// ----------------------------------------------------------------------------
module testbench;

  localparam int   LANES         = bwca_pkg::LANES;
  localparam int   CACHE_ENTRIES = bwca_pkg::CACHE_ENTRIES;
  localparam int   VCH_W         = bwca_pkg::VCH_W;
  localparam int   CFG_ADDR_W    = bwca_pkg::CFG_ADDR_W;
  localparam int   CFG_DATA_W    = bwca_pkg::CFG_DATA_W;
  localparam logic KIND_ACCUM    = bwca_pkg::KIND_ACCUM;
  localparam logic KIND_READ     = bwca_pkg::KIND_READ;
  localparam logic [VCH_W-1:0] VALID_CHANNELS_RST = bwca_pkg::VALID_CHANNELS_RST;

  localparam int LIMIT_CYCLES    = 600000;
  localparam int DRAIN_CYCLES    = 32;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_COUNT     = 8;
  localparam int PHASE_ITEMS     = 140;
  localparam int WRAP_ROUNDS     = 60;
  localparam int DIR_ROWS        = 22;

  localparam logic [CFG_ADDR_W-1:0] ADDR_VALID_CHANNELS =
    {bwca_pkg::CFG_IDX_VALID_CHANNELS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED       = 3'b100;

  localparam logic [63:0] ACT_MAX4  = 64'h7fff_7fff_7fff_7fff;
  localparam logic [63:0] ACT_MIN4  = 64'h8000_8000_8000_8000;
  localparam logic [63:0] ACT_RAMP0 = 64'h0004_0003_0002_0001;
  localparam logic [63:0] ACT_RAMP1 = 64'h0008_0007_0006_0005;
  localparam logic [63:0] SIGNS_ADD = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] SIGNS_SUB = 64'h0;
  localparam logic [11:0] WRAP_UP_IDX   = 12'h7ff;
  localparam logic [11:0] WRAP_DOWN_IDX = 12'h800;

  typedef struct packed {
    logic        kind;
    logic [11:0] index;
    logic        fresh;
    logic [11:0] base;
    logic [63:0] acts_lo;
    logic [63:0] acts_hi;
    logic [63:0] signs;
  } conv_item_t;

  typedef logic [3:0][63:0] sum_row_t;

  typedef struct packed {
    conv_item_t item;
    logic       typed;
    sum_row_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bwca_in_if  conv_in ();
  bwca_out_if sums_out ();

  binary_weight_conv_accumulate_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (conv_in),
    .out_ch     (sums_out),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the partial-sum store and the channel count
  logic [31:0]      acc_store [CACHE_ENTRIES][LANES];
  bit               entry_written [CACHE_ENTRIES];
  logic [11:0]      written_list [$];
  logic [VCH_W-1:0] vch_shadow;

  sum_row_t pending_rows [$];
  int       fail_count;
  int       cycle_count;
  bit       calm_mode;
  bit       hold_off_pending;
  string    sum_field_names [4] = '{"sums_lanes_0_1", "sums_lanes_2_3",
                                    "sums_lanes_4_5", "sums_lanes_6_7"};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{KIND_ACCUM, 12'd0,    1'b1, 12'd0,    ACT_MAX4, ACT_MAX4, SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_READ,  12'd0,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b1,
      {4{64'h0003fff8_0003fff8}}},
    '{'{KIND_ACCUM, 12'd4095, 1'b1, 12'd0,    ACT_MIN4, ACT_MIN4, SIGNS_SUB}, 1'b0, '0},
    '{'{KIND_READ,  12'd4095, 1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b1,
      {4{64'h00040000_00040000}}},
    '{'{KIND_ACCUM, 12'd1,    1'b1, 12'd0,    ACT_MIN4, ACT_MIN4, SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_READ,  12'd1,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b1,
      {4{64'hfffc0000_fffc0000}}},
    '{'{KIND_ACCUM, 12'd0,    1'b0, 12'd0,    ACT_MAX4, ACT_MAX4, SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_READ,  12'd0,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b0, '0},
    '{'{KIND_ACCUM, 12'd2,    1'b1, 12'd4095, ACT_RAMP0, ACT_RAMP1, SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_READ,  12'd2,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b1,
      {4{64'h00000001_00000001}}},
    '{'{KIND_ACCUM, 12'd3,    1'b1, 12'd4090, ACT_RAMP0, ACT_RAMP1,
        64'h55aa_0ff0_33cc_00ff}, 1'b0, '0},
    '{'{KIND_READ,  12'd3,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b0, '0},
    '{'{KIND_ACCUM, 12'd3,    1'b1, 12'd4089, 64'h8000_7fff_ffff_0001,
        64'h1234_edcb_8001_7ffe, 64'h0123_4567_89ab_cdef}, 1'b0, '0},
    '{'{KIND_READ,  12'd3,    1'b1, 12'd4095, 64'hdead_beef_0bad_f00d,
        64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff}, 1'b0, '0},
    '{'{KIND_ACCUM, 12'd2,    1'b0, 12'd0,    64'hc000_4000_fff0_0010,
        64'h8000_7fff_0001_ffff, 64'h8040_2010_0804_0201}, 1'b0, '0},
    '{'{KIND_READ,  12'd2,    1'b1, 12'hfff,  ACT_MIN4, ACT_MAX4, SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_ACCUM, 12'd5,    1'b1, 12'd0,    64'h0,    64'h0,    SIGNS_ADD}, 1'b0, '0},
    '{'{KIND_READ,  12'd5,    1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b1, '0},
    '{'{KIND_ACCUM, 12'haaa,  1'b1, 12'haaa,  64'haaaa_aaaa_aaaa_aaaa,
        64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555}, 1'b0, '0},
    '{'{KIND_ACCUM, 12'h555,  1'b1, 12'h555,  64'h5555_5555_5555_5555,
        64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
    '{'{KIND_READ,  12'haaa,  1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b0, '0},
    '{'{KIND_READ,  12'h555,  1'b0, 12'd0,    64'h0,    64'h0,    64'h0},     1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Returns 1 and the entry's sums for a read, 0 for an accumulate.
  function automatic bit predict_sums(input conv_item_t it, output sum_row_t row);
    logic [15:0] act [LANES];
    bit          live [LANES];
    logic [31:0] total;
    int          q;
    int          p;
    row = '0;
    if (it.kind == KIND_READ) begin
      for (q = 0; q < LANES / 2; q++)
        row[q] = {acc_store[it.index][2*q+1], acc_store[it.index][2*q]};
      return 1'b1;
    end
    for (p = 0; p < LANES; p++) begin
      act[p]  = (p < 4) ? it.acts_lo[16*p +: 16] : it.acts_hi[16*(p-4) +: 16];
      live[p] = (int'(it.base) + p) < int'(vch_shadow);
    end
    for (q = 0; q < LANES; q++) begin
      total = '0;
      for (p = 0; p < LANES; p++) begin
        if (live[p]) begin
          if (it.signs[8*q + p])
            total = total + {{16{act[p][15]}}, act[p]};
          else
            total = total - {{16{act[p][15]}}, act[p]};
        end
      end
      acc_store[it.index][q] = (it.fresh ? 32'd0 : acc_store[it.index][q]) + total;
    end
    if (!entry_written[it.index]) begin
      entry_written[it.index] = 1'b1;
      written_list.push_back(it.index);
    end
    return 1'b0;
  endfunction

  task automatic send_item(input conv_item_t it, input bit typed, input sum_row_t want);
    sum_row_t row;
    while (!calm_mode && $urandom_range(0, 99) < 14) begin
      conv_in.valid <= 1'b0;
      @(posedge clk);
    end
    conv_in.valid            <= 1'b1;
    conv_in.kind             <= it.kind;
    conv_in.cache_index      <= it.index;
    conv_in.start_fresh      <= it.fresh;
    conv_in.channel_base     <= it.base;
    conv_in.activations_low  <= it.acts_lo;
    conv_in.activations_high <= it.acts_hi;
    conv_in.weight_signs     <= it.signs;
    @(posedge clk);
    while (!conv_in.ready) @(posedge clk);
    if (predict_sums(it, row))
      pending_rows.push_back(typed ? want : row);
  endtask

  function automatic logic [11:0] pick_base();
    int b;
    if (vch_shadow <= 13'd4103 && $urandom_range(0, 1) == 1) begin
      b = int'(vch_shadow) - int'($urandom_range(0, 8));
      if (b < 0) b = 0;
      if (b > 4095) b = 4095;
      return 12'(b);
    end
    return 12'($urandom);
  endfunction

  function automatic logic [63:0] pick_acts();
    logic [63:0] v;
    int          p;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = ACT_MAX4;
      1: v = ACT_MIN4;
      2: begin
        for (p = 0; p < 4; p++) begin
          case ($urandom_range(0, 3))
            0:       v[16*p +: 16] = 16'h7fff;
            1:       v[16*p +: 16] = 16'h8000;
            2:       v[16*p +: 16] = 16'h0000;
            default: v[16*p +: 16] = 16'hffff;
          endcase
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // an entry never written must start fresh
  function automatic conv_item_t make_acc(input logic [11:0] idx, input bit fresh);
    return '{KIND_ACCUM, idx, fresh || !entry_written[idx], pick_base(), pick_acts(),
             pick_acts(), {$urandom, $urandom}};
  endfunction

  function automatic conv_item_t make_read(input logic [11:0] idx);
    return '{KIND_READ, idx, 1'($urandom), 12'($urandom), {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom}};
  endfunction

  task automatic wait_idle();
    conv_in.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_VALID_CHANNELS)
      vch_shadow = data[VCH_W-1:0];
    @(posedge clk);
  endtask

  task automatic check_valid_channels();
    logic [CFG_DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_VALID_CHANNELS;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== CFG_DATA_W'(vch_shadow)) begin
      $error("valid_channels: expected %0d, got %0d", vch_shadow, got);
      fail_count++;
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    sum_row_t got;
    sum_row_t want;
    if (rst_n && sums_out.valid && sums_out.ready) begin
      got = {sums_out.sums_lanes_6_7, sums_out.sums_lanes_4_5,
             sums_out.sums_lanes_2_3, sums_out.sums_lanes_0_1};
      if (pending_rows.size() == 0) begin
        $error("result beat with no read outstanding: %h", got);
        fail_count++;
      end else begin
        want = pending_rows.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            $error("%s: expected %h, got %h", sum_field_names[k], want[k], got[k]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : result_sink
    int held;
    sums_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          sums_out.ready <= 1'b0;
          @(posedge clk);
        end
      end
      sums_out.ready <= calm_mode || ($urandom_range(0, 99) >= 14);
    end
  end

  initial begin : stimulus
    logic [VCH_W-1:0] phase_vch [6] = '{13'd0, 13'd8191, 13'd4102, 13'd4103, 13'd1, 13'd4096};
    logic [VCH_W-1:0] vch;
    logic [11:0]      idx;
    int               phase_items;
    int               n;
    int               k;
    int               ph;

    cycle_count              <= 0;
    fail_count               = 0;
    calm_mode                = 1'b0;
    hold_off_pending         = 1'b0;
    rst_n                    <= 1'b0;
    conv_in.valid            <= 1'b0;
    conv_in.kind             <= KIND_ACCUM;
    conv_in.cache_index      <= '0;
    conv_in.start_fresh      <= 1'b0;
    conv_in.channel_base     <= '0;
    conv_in.activations_low  <= '0;
    conv_in.activations_high <= '0;
    conv_in.weight_signs     <= '0;
    cfg_psel                 <= 1'b0;
    cfg_penable              <= 1'b0;
    cfg_pwrite               <= 1'b0;
    cfg_paddr                <= '0;
    cfg_pwdata               <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    vch_shadow = VALID_CHANNELS_RST;
    check_valid_channels();

    for (k = 0; k < DIR_ROWS; k++)
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    wait_idle();

    cfg_write(ADDR_UNMAPPED, $urandom);
    check_valid_channels();

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph < 6)
        vch = phase_vch[ph];
      else if (ph == 6)
        vch = 13'($urandom);
      else
        vch = 13'($urandom_range(4088, 4103));
      // upper data bits beyond the register are junk once
      cfg_write(ADDR_VALID_CHANNELS,
                (ph == 3) ? (32'hffff_e000 | 32'(vch)) : 32'(vch));
      check_valid_channels();
      calm_mode = (ph == 2);
      if (ph == 1)
        hold_off_pending = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          idx = 12'($urandom);
          n   = $urandom_range(1, 6);
          for (k = 0; k < n; k++)
            send_item(make_acc(idx, (k == 0) || ($urandom_range(0, 9) == 0)), 1'b0, '0);
          send_item(make_read(idx), 1'b0, '0);
          phase_items += n + 1;
        end else begin
          if ($urandom_range(0, 1) == 1 && written_list.size() > 0)
            send_item(make_read(written_list[$urandom_range(0, written_list.size() - 1)]),
                      1'b0, '0);
          else
            send_item(make_acc(12'($urandom), 1'($urandom)), 1'b0, '0);
          phase_items++;
        end
      end
      wait_idle();
    end
    calm_mode = 1'b0;

    // long runs of extreme totals on two entries
    cfg_write(ADDR_VALID_CHANNELS, 32'(VALID_CHANNELS_RST));
    for (k = 0; k < WRAP_ROUNDS; k++) begin
      send_item(conv_item_t'{KIND_ACCUM, WRAP_UP_IDX, k == 0, 12'd0, ACT_MAX4, ACT_MAX4,
                             SIGNS_ADD}, 1'b0, '0);
      send_item(conv_item_t'{KIND_ACCUM, WRAP_DOWN_IDX, k == 0, 12'd0, ACT_MIN4, ACT_MIN4,
                             SIGNS_ADD}, 1'b0, '0);
      if (k % 20 == 19 || k == WRAP_ROUNDS - 1) begin
        send_item(make_read(WRAP_UP_IDX), 1'b0, '0);
        send_item(make_read(WRAP_DOWN_IDX), 1'b0, '0);
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_rows.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
